// ===== rtl/bpt_pkg.sv =====
// Package for the breakout phase tracker: table size, phase codes, opcodes
// and the per-instrument record type. No dependencies.
package bpt_pkg;

	localparam int INSTRUMENTS = 256;
	localparam int IDX_W = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CONSUME = 1'b1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
	localparam logic PADDR_TIMEOUT = 1'b0;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BREAK_UP = 3'd1,
		PH_HOLD_UP = 3'd2,
		PH_CONF_UP = 3'd3,
		PH_BREAK_DN = 3'd4,
		PH_HOLD_DN = 3'd5,
		PH_CONF_DN = 3'd6,
		PH_FAILED = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic active;
		logic [31:0] break_price;
		logic [31:0] confirmed_price;
		logic [31:0] highest;
		logic [31:0] lowest;
		logic returned;
		logic consumed;
		logic [47:0] break_time;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Reduces an instrument number modulo the table size. The table size is a
	// power of two, so this is a mask of the low index bits.
	function automatic logic [IDX_W-1:0] inst_index(input logic [7:0] inst);
		logic [31:0] v;
		v = {24'd0, inst} % 32'(INSTRUMENTS);
		return v[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/breakout_phase_tracker_unit.sv =====
// Breakout phase tracker top level: record table in bpt_ram, one processing
// stage with forwarding, output register and the APB timeout register.
// Depends on bpt_pkg and bpt_ram.
//
// A result passes the processing stage and then the output register.
// Throughput: one item per cycle; the table read-modify-write is forwarded.
// An update item holds the stage when the output register is full and stalled.
// Reset clears the presence bits at once, so every record reads as zero; the
// table memory itself needs no clearing pass.
module breakout_phase_tracker_unit
	import bpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  instrument,
	input  logic [31:0] mid_price,
	input  logic [47:0] timestamp_ms,
	input  logic        breakout_up,
	input  logic        breakout_down,
	input  logic [31:0] recent_high,
	input  logic [31:0] recent_low,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  instrument_out,
	output logic [2:0]  phase,
	output logic        active,
	output logic [31:0] break_price,
	output logic [31:0] last_confirmed_price,
	output logic [31:0] highest_after_break,
	output logic [31:0] lowest_after_break,
	output logic        returned_inside,
	output logic        entry_consumed,
	output logic [47:0] break_time_ms
);

	logic [31:0] timeout_q;
	logic [INSTRUMENTS-1:0] present_q;

	logic in_acc;
	logic [IDX_W-1:0] in_idx;

	logic s1_vld_q;
	logic opcode_s1;
	logic [7:0] instrument_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0] mid_s1;
	logic [47:0] now_s1;
	logic up_s1;
	logic down_s1;
	logic [31:0] hi_s1;
	logic [31:0] lo_s1;
	logic fwd_s1;
	rec_t fwd_rec_s1;

	rec_t ram_rdata;
	rec_t old_rec;
	rec_t new_rec;
	phase_t ph0;
	logic fresh;
	logic in_range;
	logic [31:0] w_hi;
	logic [31:0] w_lo;
	logic [48:0] age;
	logic age_over;
	logic s1_present;
	logic s1_go;
	logic s1_upd;
	logic s1_wr;

	logic out_vld_q;
	logic [7:0] inst_out_q;
	rec_t out_rec_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == PADDR_TIMEOUT) ? timeout_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == PADDR_TIMEOUT) begin
			timeout_q <= pwdata;
		end
	end

	assign s1_upd = (opcode_s1 == OP_UPDATE);
	assign s1_go = !(s1_upd && out_vld_q && out_stall);
	assign in_stall = s1_vld_q && !s1_go;
	assign in_acc = in_valid && !in_stall;
	assign in_idx = inst_index(instrument);

	assign s1_present = present_q[idx_s1];
	assign s1_wr = s1_vld_q && s1_go && (s1_upd || s1_present);

	bpt_ram #(
		.WIDTH(REC_W),
		.DEPTH(INSTRUMENTS)
	) u_table (
		.clk  (clk),
		.we   (s1_wr),
		.waddr(idx_s1),
		.wdata(new_rec),
		.re   (in_acc),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			opcode_s1 <= opcode;
			instrument_s1 <= instrument;
			idx_s1 <= in_idx;
			mid_s1 <= mid_price;
			now_s1 <= timestamp_ms;
			up_s1 <= breakout_up;
			down_s1 <= breakout_down;
			hi_s1 <= recent_high;
			lo_s1 <= recent_low;
			fwd_s1 <= s1_wr && (idx_s1 == in_idx);
			fwd_rec_s1 <= new_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			present_q <= '0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_go) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_vld_q && s1_go && s1_upd) begin
				present_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign age = {1'b0, now_s1} - {1'b0, old_rec.break_time};
	assign age_over = !age[48] && (age[47:0] > {16'd0, timeout_q});
	assign in_range = (mid_s1 <= hi_s1) && (mid_s1 >= lo_s1);
	assign w_hi = (mid_s1 > old_rec.highest) ? mid_s1 : old_rec.highest;
	assign w_lo = (mid_s1 < old_rec.lowest) ? mid_s1 : old_rec.lowest;

	always_comb begin
		if (fwd_s1) begin
			old_rec = fwd_rec_s1;
		end else if (s1_present) begin
			old_rec = ram_rdata;
		end else begin
			old_rec = '0;
		end

		ph0 = old_rec.active ? old_rec.phase : PH_IDLE;
		fresh = !old_rec.active || ph0 == PH_IDLE || ph0 == PH_FAILED;

		new_rec = old_rec;
		new_rec.phase = ph0;

		if (opcode_s1 == OP_CONSUME) begin
			new_rec = old_rec;
			new_rec.consumed = 1'b1;
		end else if ((up_s1 && fresh) || (!(up_s1 && (ph0 == PH_BREAK_UP || ph0 == PH_HOLD_UP))
				&& down_s1 && fresh)) begin
			new_rec.phase = up_s1 ? PH_BREAK_UP : PH_BREAK_DN;
			new_rec.break_price = mid_s1;
			new_rec.confirmed_price = mid_s1;
			new_rec.highest = mid_s1;
			new_rec.lowest = mid_s1;
			new_rec.returned = 1'b0;
			new_rec.active = 1'b1;
			new_rec.consumed = 1'b0;
			new_rec.break_time = now_s1;
		end else if (up_s1 && (ph0 == PH_BREAK_UP || ph0 == PH_HOLD_UP)) begin
			new_rec.phase = PH_CONF_UP;
			new_rec.confirmed_price = mid_s1;
			new_rec.highest = w_hi;
			new_rec.lowest = w_lo;
		end else if (down_s1 && (ph0 == PH_BREAK_DN || ph0 == PH_HOLD_DN)) begin
			new_rec.phase = PH_CONF_DN;
			new_rec.confirmed_price = mid_s1;
			new_rec.highest = w_hi;
			new_rec.lowest = w_lo;
		end else if (old_rec.active) begin
			new_rec.highest = w_hi;
			new_rec.lowest = w_lo;
			if (in_range) begin
				new_rec.returned = 1'b1;
				if (ph0 == PH_BREAK_UP || ph0 == PH_CONF_UP) begin
					new_rec.phase = PH_HOLD_UP;
				end else if (ph0 == PH_BREAK_DN || ph0 == PH_CONF_DN) begin
					new_rec.phase = PH_HOLD_DN;
				end
			end
			if ((old_rec.returned || in_range) && age_over) begin
				new_rec.phase = PH_FAILED;
				new_rec.active = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_vld_q && s1_go && s1_upd) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld_q && s1_go && s1_upd) begin
			inst_out_q <= instrument_s1;
			out_rec_q <= new_rec;
		end
	end

	assign out_valid = out_vld_q;
	assign instrument_out = inst_out_q;
	assign phase = 3'(out_rec_q.phase);
	assign active = out_rec_q.active;
	assign break_price = out_rec_q.break_price;
	assign last_confirmed_price = out_rec_q.confirmed_price;
	assign highest_after_break = out_rec_q.highest;
	assign lowest_after_break = out_rec_q.lowest;
	assign returned_inside = out_rec_q.returned;
	assign entry_consumed = out_rec_q.consumed;
	assign break_time_ms = out_rec_q.break_time;

	a_stall_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && !s1_go) |-> in_stall)
		else $error("item accepted while the stage was held");

	a_update_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && s1_go && s1_upd) |=> out_vld_q)
		else $error("update item left the stage without a result");

	a_inactive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_rec_q.active) |->
		(out_rec_q.phase == PH_IDLE || out_rec_q.phase == PH_FAILED))
		else $error("inactive record with a tracking phase");

	a_active_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_rec_q.active) |->
		(out_rec_q.phase != PH_IDLE && out_rec_q.phase != PH_FAILED))
		else $error("active record in idle or failed phase");

	a_extremes_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_rec_q.active) |-> (out_rec_q.highest >= out_rec_q.lowest))
		else $error("highest below lowest on an active record");

endmodule

// ===== rtl/bpt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used by the breakout phase tracker for its record table; no dependencies.
module bpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
